// ===== sv/sse_pkg.sv =====
// Shared types and constants for the selection sort engine.
// No dependencies; imported by every module of the block.
package sse_pkg;

    localparam int KEY_W = 32;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_EMIT
    } sse_state_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             last;
        logic             overflow;
    } sse_result_t;

endpackage

// ===== sv/sse_key_ram.sv =====
// Key store of the selection sort engine: a simple dual-port RAM.
// It has one write port and one read port, and the read data is registered.
// It depends on sse_pkg for the key width.
module sse_key_ram
    import sse_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [KEY_W-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [KEY_W-1:0] rd_data
);

    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/sse_sorter.sv =====
// Load and selection control of the selection sort engine.
// It holds the fill count, the taken mask and the minimum search, and drives
// the key RAM. It depends on sse_pkg and instantiates sse_key_ram.
module sse_sorter
    import sse_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int CW    = 7
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [KEY_W-1:0] key_in,
    input  logic             load_last,
    output logic             res_valid,
    input  logic             res_ready,
    output sse_result_t      res
);

    sse_state_t       state_reg, state_next;
    logic [CW-1:0]    fill_reg, fill_next;
    logic             dropped_reg, dropped_next;
    logic [DEPTH-1:0] taken_reg, taken_next;
    logic [CW-1:0]    scan_reg, scan_next;
    logic [CW-1:0]    round_reg, round_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             pend_taken_reg, pend_taken_next;
    logic [AW-1:0]    pend_idx_reg, pend_idx_next;
    logic             found_reg, found_next;
    logic [KEY_W-1:0] best_key_reg, best_key_next;
    logic [AW-1:0]    best_idx_reg, best_idx_next;

    logic             wr_en;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [KEY_W-1:0] rd_data;
    logic             in_xfer;
    logic             better;

    sse_key_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (fill_reg[AW-1:0]),
        .wr_data (key_in),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_xfer = in_valid && in_ready;
    assign rd_addr = scan_reg[AW-1:0];
    assign better  = pend_valid_reg && !pend_taken_reg &&
                     (!found_reg || ($signed(rd_data) < $signed(best_key_reg)));

    assign res.key      = best_key_reg;
    assign res.last     = (round_reg == (fill_reg - CW'(1)));
    assign res.overflow = dropped_reg;

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        dropped_next    = dropped_reg;
        taken_next      = taken_reg;
        scan_next       = scan_reg;
        round_next      = round_reg;
        pend_valid_next = 1'b0;
        pend_taken_next = taken_reg[rd_addr];
        pend_idx_next   = rd_addr;
        found_next      = found_reg;
        best_key_next   = best_key_reg;
        best_idx_next   = best_idx_reg;
        in_ready        = 1'b0;
        res_valid       = 1'b0;
        wr_en           = 1'b0;
        rd_en           = 1'b0;

        // The minimum is updated in the cycle after each read.
        if (better)
        begin
            found_next    = 1'b1;
            best_key_next = rd_data;
            best_idx_next = pend_idx_reg;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_xfer)
                begin
                    if (fill_reg < CW'(DEPTH))
                    begin
                        wr_en     = 1'b1;
                        fill_next = fill_reg + CW'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (load_last)
                    begin
                        state_next = ST_SCAN;
                        scan_next  = '0;
                        round_next = '0;
                        found_next = 1'b0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_reg < fill_reg)
                begin
                    rd_en           = 1'b1;
                    pend_valid_next = 1'b1;
                    scan_next       = scan_reg + CW'(1);
                end
                else if (!pend_valid_reg)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    if (res.last)
                    begin
                        state_next   = ST_LOAD;
                        taken_next   = '0;
                        fill_next    = '0;
                        dropped_next = 1'b0;
                    end
                    else
                    begin
                        state_next               = ST_SCAN;
                        taken_next[best_idx_reg] = 1'b1;
                        round_next               = round_reg + CW'(1);
                        scan_next                = '0;
                        found_next               = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            fill_reg       <= '0;
            dropped_reg    <= 1'b0;
            taken_reg      <= '0;
            scan_reg       <= '0;
            round_reg      <= '0;
            pend_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            dropped_reg    <= dropped_next;
            taken_reg      <= taken_next;
            scan_reg       <= scan_next;
            round_reg      <= round_next;
            pend_valid_reg <= pend_valid_next;
            found_reg      <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_taken_reg <= pend_taken_next;
        pend_idx_reg   <= pend_idx_next;
        best_key_reg   <= best_key_next;
        best_idx_reg   <= best_idx_next;
    end

    // A finished scan always finds an entry not yet taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (found_reg && !taken_reg[best_idx_reg]))
        else $error("sse_sorter: emit without an untaken minimum");

    // While sorting, the round count stays below the number of stored keys.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> (round_reg < fill_reg && fill_reg <= CW'(DEPTH)))
        else $error("sse_sorter: round count out of range");

    // The final result of a run returns the block to loading with a clean mask.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready && res.last)
            |=> (state_reg == ST_LOAD && fill_reg == '0 && taken_reg == '0))
        else $error("sse_sorter: state not cleared after the run");

endmodule

// ===== sv/selection_sort_engine_top.sv =====
// Top level of the selection sort engine: sorter plus output register.
// It depends on sse_pkg and instantiates sse_sorter (which holds the key RAM).
//
//  channel | signals                                  | transfer when
//  --------+------------------------------------------+-----------------------
//  input   | in_valid, in_ready, key_in, load_last    | in_valid && in_ready
//  output  | out_valid, out_ready, key_out, out_last, | out_valid && out_ready
//          | overflow                                 |
//
// Loading accepts one key per cycle; a transfer flagged load_last starts the sort.
// For each sorted key the sorter reads all n stored keys through the single RAM
// read port, waits for the last registered read, closes the search, then emits.
// in_ready is low from the last-marked transfer until the final sorted key has
// entered the output register; a stalled output holds the sorter in its emit step.
// Reset clears the control state and taken mask; the key RAM is never cleared.
module selection_sort_engine_top
    import sse_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [KEY_W-1:0] key_in,
    input  logic             load_last,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [KEY_W-1:0] key_out,
    output logic             out_last,
    output logic             overflow
);

    // Address bits index the RAM; count bits must also hold DEPTH itself.
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sse_result_t res;
    logic        res_valid;
    logic        res_ready;
    logic        out_valid_reg;
    sse_result_t out_reg;

    sse_sorter #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_sorter (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .key_in    (key_in),
        .load_last (load_last),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // The register takes a new result when empty or when its content leaves.
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign key_out   = out_reg.key;
    assign out_last  = out_reg.last;
    assign overflow  = out_reg.overflow;

    // A result handed over by the sorter appears on the output next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready) |=> (out_valid_reg && out_reg == $past(res)))
        else $error("selection_sort_engine_top: result lost in output register");

endmodule

// ===== tb/sv/sort_order_checker.sv =====
`timescale 1ns / 100ps
// Checker for the selection sort engine: watches both channels and predicts the sorted runs.
// Depends on sse_pkg for the key width and the result record.
module sort_order_checker
    import sse_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic [KEY_W-1:0] key_in,
    input  logic             load_last,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic [KEY_W-1:0] key_out,
    input  logic             out_last,
    input  logic             overflow,
    output int               err_count,
    output int               pending
);

    localparam int SHOW_LIMIT = 10;

    logic [KEY_W-1:0] held_keys [DEPTH];
    int               held_count;
    bit               keys_dropped;
    sse_result_t      sorted_keys_q [$];

    // Emits the held keys least first; among equal keys the earliest loaded goes first.
    function automatic void queue_sorted_run();
        bit          taken [DEPTH];
        int          best;
        sse_result_t res;
        for (int i = 0; i < DEPTH; i++)
        begin
            taken[i] = 1'b0;
        end
        for (int round = 0; round < held_count; round++)
        begin
            best = -1;
            for (int i = 0; i < held_count; i++)
            begin
                if (!taken[i] && (best < 0 || $signed(held_keys[i]) < $signed(held_keys[best])))
                begin
                    best = i;
                end
            end
            taken[best]  = 1'b1;
            res.key      = held_keys[best];
            res.last     = (round == held_count - 1);
            res.overflow = keys_dropped;
            sorted_keys_q.push_back(res);
        end
        held_count   = 0;
        keys_dropped = 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sse_result_t exp_res;
        if (!rst_n)
        begin
            held_count   = 0;
            keys_dropped = 1'b0;
            err_count    = 0;
            sorted_keys_q.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (sorted_keys_q.size() == 0)
                begin
                    err_count++;
                    if (err_count <= SHOW_LIMIT)
                    begin
                        $display("%0t: unexpected result key=%0d last=%0b overflow=%0b",
                                 $realtime, $signed(key_out), out_last, overflow);
                    end
                end
                else
                begin
                    exp_res = sorted_keys_q.pop_front();
                    if (exp_res.key !== key_out || exp_res.last !== out_last ||
                        exp_res.overflow !== overflow)
                    begin
                        err_count++;
                        if (err_count <= SHOW_LIMIT)
                        begin
                            $display("%0t: mismatch expected key=%0d last=%0b overflow=%0b",
                                     $realtime, $signed(exp_res.key), exp_res.last,
                                     exp_res.overflow);
                            $display("%0t:          actual   key=%0d last=%0b overflow=%0b",
                                     $realtime, $signed(key_out), out_last, overflow);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (held_count < DEPTH)
                begin
                    held_keys[held_count] = key_in;
                    held_count++;
                end
                else
                begin
                    keys_dropped = 1'b1;
                end
                if (load_last)
                begin
                    queue_sorted_run();
                end
            end
        end
        pending = sorted_keys_q.size();
    end

endmodule

// ===== tb/sv/tb_selection_sort_engine_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the selection sort engine: clock, reset, stimulus and verdict.
// Depends on sse_pkg, selection_sort_engine_top and sort_order_checker.
module tb_selection_sort_engine_top
    import sse_pkg::*;
;

    localparam int DEPTH          = 64;
    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 9;
    // A 64-key run reads every stored key for each result; the long receiver hold-off
    // adds its own length on top, so this leaves a wide margin.
    localparam int QUIET_LIMIT    = 6000;
    localparam int HOLD_CYCLES    = 800;
    localparam int DRAIN_CYCLES   = 4 * DEPTH;
    localparam int MAX_SEND_GAP   = 6;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    logic [KEY_W-1:0] key_in    = '0;
    logic             load_last = 1'b0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [KEY_W-1:0] key_out;
    logic             out_last;
    logic             overflow;

    int err_count;
    int pending;

    // Idle percentages for the two sides; changed between phases only.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // The stimulus asks for a long receiver hold-off by bumping hold_asked;
    // the receiver process notices the change and counts the stretch itself.
    int hold_asked = 0;
    int hold_seen  = 0;
    int hold_left  = 0;

    int quiet_cycles = 0;

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    selection_sort_engine_top #(
        .DEPTH     (DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .key_in    (key_in),
        .load_last (load_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .key_out   (key_out),
        .out_last  (out_last),
        .overflow  (overflow)
    );

    sort_order_checker #(
        .DEPTH     (DEPTH)
    ) checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .key_in    (key_in),
        .load_last (load_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .key_out   (key_out),
        .out_last  (out_last),
        .overflow  (overflow),
        .err_count (err_count),
        .pending   (pending)
    );

    // Receiver side. Every falling edge makes exactly one decision about
    // out_ready: either part of a requested hold-off, or a random stall.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_asked != hold_seen)
        begin
            out_ready <= 1'b0;
            hold_seen <= hold_asked;
            hold_left <= HOLD_CYCLES;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: a long run of cycles without any transfer on either channel
    // means the block has hung, so the run is ended as a failure.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one key and holds it until the transfer happens. An optional idle
    // gap comes first; valid stays high from one key to the next otherwise.
    task automatic send_key(input logic [KEY_W-1:0] key, input logic last);
        int gap;
        if ($urandom_range(99) < send_idle_pct)
        begin
            gap = $urandom_range(MAX_SEND_GAP, 1);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        key_in    <= key;
        load_last <= last;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Keys are drawn so that duplicates and both signed extremes turn up often,
    // while most keys are fully random so that every bit toggles.
    function automatic logic [KEY_W-1:0] pick_key();
        int sel;
        int near_zero;
        sel = $urandom_range(15);
        near_zero = int'($urandom_range(6)) - 3;
        if (sel < 4)
        begin
            return near_zero;
        end
        else if (sel == 4)
        begin
            return 32'h8000_0000;
        end
        else if (sel == 5)
        begin
            return 32'h7FFF_FFFF;
        end
        return $urandom;
    endfunction

    // A set of n keys with the last mark on the final one. Beyond DEPTH keys
    // the surplus is dropped and the run should carry the overflow flag.
    task automatic send_set(input int n);
        for (int i = 0; i < n; i++)
        begin
            send_key(pick_key(), i == n - 1);
        end
    endtask

    // Mostly short sets, now and then a medium one, until the budget is spent.
    task automatic send_random_sets(input int budget);
        int n;
        while (budget > 0)
        begin
            if ($urandom_range(7) == 0)
            begin
                n = $urandom_range(24, 11);
            end
            else
            begin
                n = $urandom_range(10, 1);
            end
            if (n > budget)
            begin
                n = budget;
            end
            send_set(n);
            budget -= n;
        end
    endtask

    // The sender stops offering and waits until every predicted result has
    // been seen; the watchdog guards against this never happening.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // First phase: the sender idles now and then, the receiver mostly.
        send_idle_pct = 34;
        recv_idle_pct = 66;

        // A set holding only the most negative key, then only the most positive.
        send_key(32'h8000_0000, 1'b1);
        send_key(32'h7FFF_FFFF, 1'b1);
        // Both extremes, zero, plus and minus one, with repeated values.
        send_key(32'h0000_0000, 1'b0);
        send_key(32'hFFFF_FFFF, 1'b0);
        send_key(32'h0000_0001, 1'b0);
        send_key(32'h7FFF_FFFF, 1'b0);
        send_key(32'h8000_0000, 1'b0);
        send_key(32'h0000_0000, 1'b0);
        send_key(32'hFFFF_FFFF, 1'b1);
        // Keys loaded in descending order.
        send_key(32'd5, 1'b0);
        send_key(32'd4, 1'b0);
        send_key(32'd3, 1'b0);
        send_key(32'd2, 1'b0);
        send_key(32'd1, 1'b1);
        // Every key equal.
        send_key(32'd42, 1'b0);
        send_key(32'd42, 1'b0);
        send_key(32'd42, 1'b0);
        send_key(32'd42, 1'b1);
        // Two keys already in order, with a negative first.
        send_key(-32'sd100, 1'b0);
        send_key(32'd100, 1'b1);

        // A set that fills the store exactly: no key is dropped.
        send_set(DEPTH);
        send_random_sets(70);
        wait_for_results();

        // Second phase: the roles are swapped.
        send_idle_pct = 66;
        recv_idle_pct = 34;

        // The receiver holds off for a long stretch while an overfull set is
        // loaded and sorted, so the output register and the sorter back up and
        // the following set is stalled at the input. The last-marked key of
        // the overfull set is itself one of the dropped keys.
        hold_asked = hold_asked + 1;
        send_set(DEPTH + 3);
        send_set(5);
        send_random_sets(75);
        wait_for_results();

        // Third phase: neither side idles.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_sets(75);
        wait_for_results();

        // Give the block time to show any stray result before the verdict.
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (err_count == 0 && pending == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/sse_pkg.sv
sv/sse_key_ram.sv
sv/sse_sorter.sv
sv/selection_sort_engine_top.sv
tb/sv/sort_order_checker.sv
tb/sv/tb_selection_sort_engine_top.sv
